// ===== rtl/ecdf_pkg.sv =====
// ----------------------------------------------------------------------------
// ecdf_pkg
// Opcodes, status codes and widths shared by the empirical CDF store.
// ----------------------------------------------------------------------------
package ecdf_pkg;
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int PROB_BITS  = 16;
  localparam int COUNT_BITS = 7;
  localparam int FIELD_BITS = 24;
endpackage

// ===== rtl/ecdf_frac_div.sv =====
// ----------------------------------------------------------------------------
// ecdf_frac_div
// Restoring divider: q = floor(num * 2^16 / den), one quotient bit a cycle.
// Caller guarantees num < den.
// ----------------------------------------------------------------------------
module ecdf_frac_div import ecdf_pkg::*; #(
  parameter int W = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [W-1:0]         num,
  input  logic [W-1:0]         den,
  output logic                 done,
  output logic [PROB_BITS-1:0] quo
);
  logic [W:0]           rem_r;
  logic [W-1:0]         den_r;
  logic [PROB_BITS-1:0] quo_r;
  logic [4:0]           cnt_r;
  logic                 busy_r;
  logic [W:0]           sh;

  assign sh   = {rem_r[W-1:0], 1'b0};
  assign quo  = quo_r;
  assign done = busy_r && (cnt_r == 5'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(PROB_BITS);
      rem_r  <= {1'b0, num};
      den_r  <= den;
      quo_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == 5'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 5'd1;
        if (sh >= {1'b0, den_r}) begin
          rem_r <= sh - {1'b0, den_r};
          quo_r <= {quo_r[PROB_BITS-2:0], 1'b1};
        end else begin
          rem_r <= sh;
          quo_r <= {quo_r[PROB_BITS-2:0], 1'b0};
        end
      end
    end
  end
endmodule

// ===== rtl/empirical_cdf_sorted_store.sv =====
// ----------------------------------------------------------------------------
// empirical_cdf_sorted_store
// Sorted sample store with insert, clear and interpolated CDF query.
// ----------------------------------------------------------------------------
// One item at a time; the result appears after a data-dependent walk from the
// input transfer and the input stays closed until the result transfer. Clear,
// no-op and a dropped insert go straight to the done state. Insert reads the
// store downward from the top through its single-port memory, with a read, a
// compare and a write-back per shifted entry. Query checks minimum and maximum
// (an early exit below the minimum or above the maximum), runs a binary
// search, walks past equal neighbours, reads the upper neighbour, multiplies
// and then divides in a 16-step restoring divider. The result sits in an
// output register; no clearing pass is needed after reset.
module empirical_cdf_sorted_store import ecdf_pkg::*; #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_opcode,
  input  logic [FIELD_BITS-1:0] in_sample_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PROB_BITS-1:0]  out_probability,
  output logic [1:0]            out_status,
  output logic [COUNT_BITS-1:0] out_sample_count
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = VALUE_BITS + 2 * CW + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_IRD   = 4'd1;
  localparam logic [3:0] S_ICMP  = 4'd2;
  localparam logic [3:0] S_QMIN  = 4'd3;
  localparam logic [3:0] S_QMAX  = 4'd4;
  localparam logic [3:0] S_QBS   = 4'd5;
  localparam logic [3:0] S_QEQ   = 4'd6;
  localparam logic [3:0] S_QHI   = 4'd7;
  localparam logic [3:0] S_QMUL  = 4'd8;
  localparam logic [3:0] S_QDIV  = 4'd9;
  localparam logic [3:0] S_QWAIT = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_WAIT  = 4'd12;

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rd_r;
  logic [AW-1:0]         addr;
  logic                  we;
  logic [VALUE_BITS-1:0] wd;

  logic [3:0]            st_r;
  logic [CW-1:0]         n_r;
  logic [VALUE_BITS-1:0] x_r, slo_r, shi_r;
  logic [CW-1:0]         lo_r, hi_r, pos_r, mid;
  logic                  pend_r;
  logic [PROB_BITS-1:0]  prob_r;
  logic [1:0]            stat_r;
  logic                  ov_r;
  logic [DW-1:0]         num_r, den_r;
  logic                  dstart;
  logic                  ddone;
  logic [PROB_BITS-1:0]  dquo;
  logic [CW:0]           n1;

  assign mid = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign n1  = {1'b0, n_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wd;
    rd_r <= mem[addr];
  end

  ecdf_frac_div #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart),
    .num(num_r), .den(den_r), .done(ddone), .quo(dquo)
  );

  assign in_ready         = (st_r == S_IDLE) && !ov_r;
  assign out_valid        = ov_r;
  assign out_probability  = prob_r;
  assign out_status       = stat_r;
  assign out_sample_count = COUNT_BITS'(n_r);
  assign dstart           = (st_r == S_QDIV);

  always_comb begin
    addr = '0;
    we   = 1'b0;
    wd   = x_r;
    case (st_r)
      S_IRD: begin
        if (pend_r) begin
          addr = AW'(pos_r);
          we   = 1'b1;
          wd   = rd_r;
        end else begin
          addr = AW'(pos_r - 1'b1);
        end
      end
      S_ICMP: begin
        if (pend_r && rd_r > x_r) begin
          addr = AW'(pos_r - 1'b1);
        end else begin
          addr = AW'(pos_r);
          we   = 1'b1;
          wd   = x_r;
        end
      end
      S_QMIN:  addr = AW'(lo_r);
      S_QMAX:  addr = AW'(n_r - 1'b1);
      S_QBS:   addr = AW'(mid);
      S_QEQ:   addr = AW'(lo_r + 1'b1);
      S_QHI:   addr = AW'(lo_r + 1'b1);
      default: addr = AW'(lo_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      n_r    <= '0;
      ov_r   <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            x_r    <= VALUE_BITS'(in_sample_value);
            prob_r <= '0;
            stat_r <= ST_OK;
            pend_r <= 1'b0;
            st_r   <= S_DONE;
            case (in_opcode)
              OP_CLEAR: n_r <= '0;
              OP_INSERT: begin
                if (n_r >= CW'(CAPACITY)) begin
                  stat_r <= ST_FULL;
                end else begin
                  pos_r <= n_r;
                  st_r  <= S_IRD;
                end
              end
              OP_QUERY: begin
                if (n_r == '0) begin
                  stat_r <= ST_EMPTY;
                end else begin
                  lo_r <= '0;
                  hi_r <= n_r - 1'b1;
                  st_r <= S_QMIN;
                end
              end
              default: ;
            endcase
          end
        end
        S_IRD: begin
          if (pend_r) begin
            pend_r <= 1'b0;
            pos_r  <= pos_r - 1'b1;
            st_r   <= S_IRD;
          end else if (pos_r == '0) begin
            st_r <= S_ICMP;
          end else begin
            st_r <= S_ICMP;
            pend_r <= 1'b1;
          end
        end
        S_ICMP: begin
          // rd_r holds s[pos-1] when a read was issued
          if (pend_r && rd_r > x_r) begin
            st_r <= S_IRD;
          end else begin
            pend_r <= 1'b0;
            st_r   <= S_WAIT;
            n_r    <= n_r + 1'b1;
          end
        end
        S_QMIN: st_r <= S_QMAX;
        S_QMAX: begin
          if (x_r < rd_r) begin
            st_r <= S_DONE;
          end else begin
            slo_r <= rd_r;
            st_r  <= S_QHI;
            pend_r <= 1'b1;
          end
        end
        S_QHI: begin
          if (pend_r) begin
            pend_r <= 1'b0;
            if (x_r > rd_r) begin
              prob_r <= '1;
              st_r   <= S_DONE;
            end else begin
              st_r <= S_QBS;
            end
          end else begin
            shi_r <= rd_r;
            st_r  <= S_QMUL;
          end
        end
        S_QBS: begin
          if (mid == lo_r) begin
            pend_r <= 1'b0;
            st_r   <= S_QEQ;
          end else if (!pend_r) begin
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (x_r < rd_r) hi_r <= mid;
            else lo_r <= mid;
          end
        end
        S_QEQ: begin
          if (lo_r + 1'b1 >= n_r) begin
            num_r <= DW'(n_r);
            den_r <= DW'(n1);
            st_r  <= S_QDIV;
          end else if (!pend_r) begin
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (rd_r == slo_r) begin
              lo_r <= lo_r + 1'b1;
            end else begin
              shi_r <= rd_r;
              st_r  <= S_QMUL;
            end
          end
        end
        S_QMUL: begin
          num_r <= DW'(({1'b0, lo_r} + 1'b1) * (shi_r - slo_r)) + DW'(x_r - slo_r);
          den_r <= DW'((shi_r - slo_r) * n1);
          st_r  <= S_QDIV;
        end
        S_QDIV: st_r <= S_QWAIT;
        S_QWAIT: begin
          if (ddone) begin
            prob_r <= dquo;
            st_r   <= S_DONE;
          end
        end
        S_WAIT: st_r <= S_DONE;
        S_DONE: begin
          ov_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      if (st_r == S_QEQ && pend_r == 1'b0 && lo_r + 1'b1 < n_r) slo_r <= rd_r;
    end
  end
endmodule

// ===== rtl/ecdf_checker.sv =====
// ----------------------------------------------------------------------------
// ecdf_checker
// Port-level checks for the empirical CDF store.
// ----------------------------------------------------------------------------
module ecdf_checker import ecdf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [PROB_BITS-1:0]  out_probability,
  input logic [1:0]            out_status,
  input logic [COUNT_BITS-1:0] out_sample_count
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_probability)
      && $stable(out_status) && $stable(out_sample_count))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accepted with result pending");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second transfer while busy");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_probability == '0)
    else $error("flagged item carries probability");
endmodule

bind empirical_cdf_sorted_store ecdf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_probability(out_probability), .out_status(out_status),
  .out_sample_count(out_sample_count)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for empirical_cdf_sorted_store. A directed table covers
// the extremes and corner cases of the insert, query and clear operations.
// A long random run follows. Typed rows are held to the table, the rest field
// by field to an in-bench model of the sorted store, its binary search and its
// interpolation. The run is repeated under several sender and receiver
// throttling mixes, with a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top import ecdf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY   = 64;
  localparam int LIMIT      = 2000000;

  typedef struct packed {
    logic [PROB_BITS-1:0]  prob;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] count;
  } cdf_result_t;

  typedef struct packed {
    logic [1:0]            op;
    logic [FIELD_BITS-1:0] value;
    logic                  typed;
    logic [PROB_BITS-1:0]  prob;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] count;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_opcode = OP_NOP;
  logic [FIELD_BITS-1:0] in_sample_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PROB_BITS-1:0]  out_probability;
  logic [1:0]            out_status;
  logic [COUNT_BITS-1:0] out_sample_count;

  logic [FIELD_BITS-1:0] model_vals [CAPACITY];
  int unsigned           model_count = 0;
  cdf_result_t           pending_q[$];
  int                    err_cnt = 0;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    hold_left = 0;
  int                    cycle_cnt = 0;

  stim_row_t dir_rows [] = '{
    '{OP_QUERY,  24'd0,        1'b1, 16'd0,     ST_EMPTY, 7'd0},
    '{OP_INSERT, 24'd100,      1'b1, 16'd0,     ST_OK,    7'd1},
    '{OP_QUERY,  24'd100,      1'b1, 16'd32768, ST_OK,    7'd1},
    '{OP_QUERY,  24'd99,       1'b1, 16'd0,     ST_OK,    7'd1},
    '{OP_QUERY,  24'd101,      1'b1, 16'd65535, ST_OK,    7'd1},
    '{OP_INSERT, 24'd0,        1'b1, 16'd0,     ST_OK,    7'd2},
    '{OP_INSERT, 24'hFFFFFF,   1'b1, 16'd0,     ST_OK,    7'd3},
    '{OP_INSERT, 24'd100,      1'b1, 16'd0,     ST_OK,    7'd4},
    '{OP_QUERY,  24'd100,      1'b0, 16'd0,     ST_OK,    7'd0},
    '{OP_QUERY,  24'hFFFFFF,   1'b1, 16'd52428, ST_OK,    7'd4},
    '{OP_QUERY,  24'd0,        1'b0, 16'd0,     ST_OK,    7'd0},
    '{OP_QUERY,  24'd50,       1'b0, 16'd0,     ST_OK,    7'd0},
    '{OP_QUERY,  24'h7FFFFF,   1'b0, 16'd0,     ST_OK,    7'd0},
    '{OP_NOP,    24'hFFFFFF,   1'b1, 16'd0,     ST_OK,    7'd4},
    '{OP_INSERT, 24'hAAAAAA,   1'b1, 16'd0,     ST_OK,    7'd5},
    '{OP_QUERY,  24'h555555,   1'b0, 16'd0,     ST_OK,    7'd0},
    '{OP_CLEAR,  24'h123456,   1'b1, 16'd0,     ST_OK,    7'd0},
    '{OP_QUERY,  24'd100,      1'b1, 16'd0,     ST_EMPTY, 7'd0},
    '{OP_NOP,    24'd0,        1'b1, 16'd0,     ST_OK,    7'd0}
  };

  empirical_cdf_sorted_store dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_probability  (out_probability),
    .out_status       (out_status),
    .out_sample_count (out_sample_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("empirical_cdf_sorted_store regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cdf_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected transfer: probability %0d status %0d count %0d",
               out_probability, out_status, out_sample_count);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (out_probability !== want.prob) begin
          $error("probability: expected %0d, got %0d", want.prob, out_probability);
          err_cnt++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          err_cnt++;
        end
        if (out_sample_count !== want.count) begin
          $error("sample_count: expected %0d, got %0d", want.count, out_sample_count);
          err_cnt++;
        end
      end
    end
  end

  // floor(num * 65536 / den) by restoring division
  function automatic longint unsigned frac16(longint unsigned num, longint unsigned den);
    longint unsigned r;
    longint unsigned q;
    r = num;
    q = 0;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic logic [PROB_BITS-1:0] cdf_of(logic [FIELD_BITS-1:0] x);
    int unsigned n, lo, hi, mid;
    longint unsigned d, a, q;
    n = model_count;
    if (x < model_vals[0]) return '0;
    if (x > model_vals[n-1]) return 16'hFFFF;
    lo = 0;
    hi = n - 1;
    mid = (hi + lo) / 2;
    while (mid != lo) begin
      if (x < model_vals[mid]) hi = mid;
      else lo = mid;
      mid = (hi + lo) / 2;
    end
    while (lo + 1 < n && model_vals[lo] == model_vals[lo+1]) lo++;
    if (lo + 1 >= n) return PROB_BITS'(frac16(n, n + 1));
    d = model_vals[lo+1] - model_vals[lo];
    a = (lo + 1) * d + (x - model_vals[lo]);
    q = frac16(a, d * (n + 1));
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic cdf_result_t store_update(logic [1:0] op, logic [FIELD_BITS-1:0] x);
    cdf_result_t res;
    int unsigned pos;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_CLEAR: model_count = 0;
      OP_INSERT: begin
        if (model_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          pos = model_count;
          while (pos > 0 && model_vals[pos-1] > x) begin
            model_vals[pos] = model_vals[pos-1];
            pos--;
          end
          model_vals[pos] = x;
          model_count++;
        end
      end
      OP_QUERY: begin
        if (model_count == 0) res.status = ST_EMPTY;
        else res.prob = cdf_of(x);
      end
      default: ;
    endcase
    res.count = COUNT_BITS'(model_count);
    return res;
  endfunction

  // offer one item; valid stays high on return
  task automatic offer(logic [1:0] op, logic [FIELD_BITS-1:0] x,
                       logic typed, cdf_result_t typed_res);
    cdf_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_sample_value <= x;
    do @(posedge clk); while (!in_ready);
    res = store_update(op, x);
    pending_q.push_back(typed ? typed_res : res);
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_value();
    logic [FIELD_BITS-1:0] base;
    case ($urandom_range(0, 3))
      0: return FIELD_BITS'($urandom());
      1: return FIELD_BITS'($urandom_range(0, 31));
      default: begin
        if (model_count == 0) return FIELD_BITS'($urandom());
        base = model_vals[$urandom_range(0, model_count - 1)];
        return FIELD_BITS'(base + $urandom_range(0, 4) - 2);
      end
    endcase
  endfunction

  task automatic random_item();
    int r;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    if (r < 2) op = OP_CLEAR;
    else if (r < 47) op = OP_INSERT;
    else if (r < 93) op = OP_QUERY;
    else if (r < 96) op = OP_NOP;
    else op = 2'($urandom_range(0, 3));
    offer(op, pick_value(), 1'b0, '0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      offer(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed,
            '{dir_rows[i].prob, dir_rows[i].status, dir_rows[i].count});

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      repeat (360) random_item();
    end

    send_idle_pct = 0;
    recv_stall_pct = 10;
    hold_left = 600;
    repeat (50) random_item();

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    @(posedge clk);
    repeat (40) random_item();

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("empirical_cdf_sorted_store regression: pass");
    end else begin
      $display("empirical_cdf_sorted_store regression: fail");
    end
    $finish;
  end
endmodule
